// ===== rtl/core/ray_unit_box_slab_test_assert.svh =====
// Assertion macros shared by the checker of the ray box slab test block.
// Plain text only; no other file defines macros.
`ifndef RAY_UNIT_BOX_SLAB_TEST_ASSERT_SVH
`define RAY_UNIT_BOX_SLAB_TEST_ASSERT_SVH

// Condition c must hold in the same cycle as a.
`define RUBST_ASSERT_SAME(lbl, clk, rst_n, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// Condition c must hold in the cycle after a.
`define RUBST_ASSERT_NEXT(lbl, clk, rst_n, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

// ===== rtl/core/rubst_pkg.sv =====
// Package of the ray box slab test block: widths, constants and lane types.
// Depends on nothing; every other file of the block but the macro header imports it.
package rubst_pkg;

  localparam int Q_W           = 32;
  localparam int THR_W         = 16;
  localparam int QUO_W         = 32;
  localparam int REM_W         = 64;
  localparam int NUM_AXES      = 3;
  localparam int NUM_LANES     = 2 * NUM_AXES;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [THR_W-1:0] THR_RESET = 16'd7;
  localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;

  // How one slab bound is produced: by division or forced to an extreme.
  typedef enum logic [1:0] {
    BOUND_DIV,
    BOUND_MAX,
    BOUND_MIN
  } bound_e;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [Q_W-1:0]   dmag;
    logic [QUO_W-1:0] quo;
    logic             neg;
    bound_e           kind;
  } lane_t;

  typedef lane_t [NUM_LANES-1:0] lanes_t;

endpackage

// ===== rtl/core/rubst_if.sv =====
// Channel interfaces of the ray box slab test block: ray, result and config.
// Depends on rubst_pkg for the field widths.
interface rubst_ray_if;
  import rubst_pkg::*;
  logic                  valid;
  logic                  ready;
  logic signed [Q_W-1:0] origin_x;
  logic signed [Q_W-1:0] origin_y;
  logic signed [Q_W-1:0] origin_z;
  logic signed [Q_W-1:0] dir_x;
  logic signed [Q_W-1:0] dir_y;
  logic signed [Q_W-1:0] dir_z;
  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  input ready);
  modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                output ready);
endinterface

interface rubst_hit_if;
  import rubst_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic signed [Q_W-1:0] t_near;
  logic signed [Q_W-1:0] t_far;
  modport source (output valid, hit, t_near, t_far, input ready);
  modport sink (input valid, hit, t_near, t_far, output ready);
endinterface

interface rubst_cfg_if;
  import rubst_pkg::*;
  logic             valid;
  logic             ready;
  logic [THR_W-1:0] parallel_threshold;
  modport source (output valid, parallel_threshold, input ready);
  modport sink (input valid, parallel_threshold, output ready);
endinterface

// ===== rtl/core/rubst_divider.sv =====
// Pipelined restoring divider for the six slab lanes, one quotient bit per stage.
// Depends on rubst_pkg for the lane types.
module rubst_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rubst_pkg::lanes_t in_lanes_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rubst_pkg::lanes_t out_lanes_o
);
  import rubst_pkg::*;

  lanes_t             pipe_q [QUO_W];
  lanes_t             feed   [QUO_W];
  logic [QUO_W-1:0]   vld_q;
  logic [QUO_W-1:0]   feed_v;
  logic [QUO_W:0]     rdy;

  assign rdy[QUO_W] = out_ready_i;
  assign in_ready_o = rdy[0];

  for (genvar s = 0; s < QUO_W; s++) begin : g_step
    localparam int BIT = QUO_W - 1 - s;
    lanes_t nxt;

    if (s == 0) begin : g_head
      assign feed[s]   = in_lanes_i;
      assign feed_v[s] = in_valid_i;
    end else begin : g_body
      assign feed[s]   = pipe_q[s-1];
      assign feed_v[s] = vld_q[s-1];
    end

    // A stage moves on when it is empty or its successor takes its beat.
    assign rdy[s] = !vld_q[s] || rdy[s+1];

    always_comb begin
      logic [REM_W-1:0] trial;
      nxt = feed[s];
      for (int l = 0; l < NUM_LANES; l++) begin
        trial = REM_W'(feed[s][l].dmag) << BIT;
        if (feed[s][l].kind == BOUND_DIV && feed[s][l].rem >= trial) begin
          nxt[l].rem      = feed[s][l].rem - trial;
          nxt[l].quo[BIT] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (rdy[s]) begin
        vld_q[s] <= feed_v[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[s] && feed_v[s]) begin
        pipe_q[s] <= nxt;
      end
    end
  end

  assign out_valid_o = vld_q[QUO_W-1];
  assign out_lanes_o = pipe_q[QUO_W-1];

endmodule

// ===== rtl/core/ray_unit_box_slab_test.sv =====
// Top level of the ray against unit box slab test.
// Depends on rubst_pkg, the channel interfaces and rubst_divider.

// This block clips one ray per beat against the box from -1 to 1 on every
// axis and returns the entry distance, the exit distance and a hit flag,
// all in signed fixed point with FRAC_BITS fraction bits. It accepts a new
// ray in every cycle and keeps that rate indefinitely while the result side
// takes its beats. Each ray passes through one input register that forms
// the six numerators, checks for parallel directions and for quotient
// overflow, then 32 divider stages that each settle one quotient bit of all
// six slab divisions, then three stages that saturate and order the bounds,
// reduce them over the axes, and compare them. The 32-bit quotient width of
// the divider sets the number of divider stages. Every stage has its own
// valid bit and moves whenever the stage after it is empty or moving, so a
// stall on the result side fills empty stages first and drops nothing. The
// parallel threshold register resets to 7 and is written through the config
// channel, which is always ready; write it only while no ray is in flight.
module ray_unit_box_slab_test #(
  parameter int FRAC_BITS = rubst_pkg::FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rubst_cfg_if.sink   cfg_i,
  rubst_ray_if.sink   ray_i,
  rubst_hit_if.source hit_o
);
  import rubst_pkg::*;

  localparam logic signed [Q_W:0] ONE = (Q_W+1)'(1) << FRAC_BITS;

  // Parallel threshold register.
  logic [THR_W-1:0] thr_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (cfg_i.valid) begin
      thr_q <= cfg_i.parallel_threshold;
    end
  end

  // Input register stage.
  logic                  a_vld_q;
  logic                  a_rdy;
  logic signed [Q_W-1:0] org_q [NUM_AXES];
  logic signed [Q_W-1:0] dir_q [NUM_AXES];
  logic                  div_in_ready;

  assign a_rdy       = !a_vld_q || div_in_ready;
  assign ray_i.ready = a_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (a_rdy) begin
      a_vld_q <= ray_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_rdy && ray_i.valid) begin
      org_q[0] <= ray_i.origin_x;
      org_q[1] <= ray_i.origin_y;
      org_q[2] <= ray_i.origin_z;
      dir_q[0] <= ray_i.dir_x;
      dir_q[1] <= ray_i.dir_y;
      dir_q[2] <= ray_i.dir_z;
    end
  end

  // Numerators, parallel check and overflow check for each lane. Lane
  // 2*axis divides (-1 - origin), lane 2*axis+1 divides (1 - origin).
  lanes_t front;

  always_comb begin
    logic signed [Q_W:0] num [2];
    logic [Q_W-1:0]      nmag;
    logic [Q_W-1:0]      dmag;
    logic [REM_W-1:0]    scaled;
    logic                par;
    logic                unbounded;
    logic                ovf;
    logic                neg;
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      num[0]    = -ONE - (Q_W+1)'(org_q[ax]);
      num[1]    = ONE - (Q_W+1)'(org_q[ax]);
      dmag      = dir_q[ax][Q_W-1] ? Q_W'(-dir_q[ax]) : Q_W'(dir_q[ax]);
      par       = (dir_q[ax] == '0) || (dmag < Q_W'(thr_q));
      unbounded = par && (num[0] == '0 || num[1] == '0);
      for (int k = 0; k < 2; k++) begin
        nmag   = num[k][Q_W] ? Q_W'(-num[k]) : num[k][Q_W-1:0];
        scaled = REM_W'(nmag) << FRAC_BITS;
        // The quotient cannot fit 32 magnitude bits once this holds.
        ovf    = scaled[REM_W-1:QUO_W] >= dmag;
        neg    = num[k][Q_W] ^ dir_q[ax][Q_W-1];
        front[2*ax+k].rem  = scaled;
        front[2*ax+k].dmag = dmag;
        front[2*ax+k].quo  = '0;
        front[2*ax+k].neg  = neg;
        if (unbounded) begin
          // A side with zero numerator on a parallel axis leaves it open.
          front[2*ax+k].kind = (k == 0) ? BOUND_MIN : BOUND_MAX;
        end else if (par) begin
          front[2*ax+k].kind = (!num[k][Q_W] && num[k] != '0) ? BOUND_MAX : BOUND_MIN;
        end else if (ovf) begin
          front[2*ax+k].kind = neg ? BOUND_MIN : BOUND_MAX;
        end else begin
          front[2*ax+k].kind = BOUND_DIV;
        end
      end
    end
  end

  logic   div_out_valid;
  logic   b1_rdy;
  lanes_t div_out;

  rubst_divider u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (a_vld_q),
    .in_ready_o  (div_in_ready),
    .in_lanes_i  (front),
    .out_valid_o (div_out_valid),
    .out_ready_i (b1_rdy),
    .out_lanes_o (div_out)
  );

  // Saturate each quotient, then order the two bounds of each axis.
  logic signed [Q_W-1:0] bound [NUM_LANES];
  logic signed [Q_W-1:0] lo_d  [NUM_AXES];
  logic signed [Q_W-1:0] hi_d  [NUM_AXES];

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      unique case (div_out[l].kind)
        BOUND_MAX: bound[l] = Q_MAX;
        BOUND_MIN: bound[l] = Q_MIN;
        default: begin
          // A magnitude of 2^31 or more saturates; for a negative result
          // exactly 2^31 is the smallest value, which is the same thing.
          if (div_out[l].quo[QUO_W-1]) begin
            bound[l] = div_out[l].neg ? Q_MIN : Q_MAX;
          end else if (div_out[l].neg) begin
            bound[l] = -$signed(div_out[l].quo);
          end else begin
            bound[l] = $signed(div_out[l].quo);
          end
        end
      endcase
    end
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      if (bound[2*ax] > bound[2*ax+1]) begin
        lo_d[ax] = bound[2*ax+1];
        hi_d[ax] = bound[2*ax];
      end else begin
        lo_d[ax] = bound[2*ax];
        hi_d[ax] = bound[2*ax+1];
      end
    end
  end

  logic                  b1_vld_q;
  logic                  b2_rdy;
  logic signed [Q_W-1:0] lo_q [NUM_AXES];
  logic signed [Q_W-1:0] hi_q [NUM_AXES];

  assign b1_rdy = !b1_vld_q || b2_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_vld_q <= 1'b0;
    end else if (b1_rdy) begin
      b1_vld_q <= div_out_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b1_rdy && div_out_valid) begin
      lo_q <= lo_d;
      hi_q <= hi_d;
    end
  end

  // Largest entry and smallest exit over the three axes.
  logic signed [Q_W-1:0] near_d;
  logic signed [Q_W-1:0] far_d;

  always_comb begin
    near_d = lo_q[0];
    far_d  = hi_q[0];
    for (int ax = 1; ax < NUM_AXES; ax++) begin
      if (lo_q[ax] > near_d) begin
        near_d = lo_q[ax];
      end
      if (hi_q[ax] < far_d) begin
        far_d = hi_q[ax];
      end
    end
  end

  logic                  b2_vld_q;
  logic                  b3_rdy;
  logic signed [Q_W-1:0] near_q;
  logic signed [Q_W-1:0] far_q;

  assign b2_rdy = !b2_vld_q || b3_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b2_vld_q <= 1'b0;
    end else if (b2_rdy) begin
      b2_vld_q <= b1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b2_rdy && b1_vld_q) begin
      near_q <= near_d;
      far_q  <= far_d;
    end
  end

  // Output register with the hit compare.
  logic                  out_vld_q;
  logic                  hit_q;
  logic signed [Q_W-1:0] t_near_q;
  logic signed [Q_W-1:0] t_far_q;

  assign b3_rdy = !out_vld_q || hit_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (b3_rdy) begin
      out_vld_q <= b2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b3_rdy && b2_vld_q) begin
      hit_q    <= near_q <= far_q;
      t_near_q <= near_q;
      t_far_q  <= far_q;
    end
  end

  assign hit_o.valid  = out_vld_q;
  assign hit_o.hit    = hit_q;
  assign hit_o.t_near = t_near_q;
  assign hit_o.t_far  = t_far_q;

endmodule

// ===== rtl/core/rubst_checker.sv =====
// Port-level checker of the ray box slab test block and its bind statement.
// Depends on rubst_pkg and the assertion macro header.
`include "ray_unit_box_slab_test_assert.svh"

module rubst_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            out_valid_i,
  input logic                            out_ready_i,
  input logic                            hit_i,
  input logic signed [rubst_pkg::Q_W-1:0] t_near_i,
  input logic signed [rubst_pkg::Q_W-1:0] t_far_i
);
  import rubst_pkg::*;

  `RUBST_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i, "result beat dropped while stalled")
  `RUBST_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(t_near_i) && $stable(t_far_i) && $stable(hit_i), "stalled result changed")
  `RUBST_ASSERT_SAME(a_hit_flag, clk_i, rst_ni, out_valid_i, hit_i == (t_near_i <= t_far_i), "hit flag disagrees with distances")
  `RUBST_ASSERT_SAME(a_near_max, clk_i, rst_ni, out_valid_i && hit_i && t_near_i == Q_MAX, t_far_i == Q_MAX, "entry at the largest value without matching exit")

endmodule

bind ray_unit_box_slab_test rubst_checker u_rubst_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (hit_o.valid),
  .out_ready_i (hit_o.ready),
  .hit_i       (hit_o.hit),
  .t_near_i    (hit_o.t_near),
  .t_far_i     (hit_o.t_far)
);
